@@ rtl/tfrc_pkg.sv @@
// shared types and constants of the four-register cpu execute block
package tfrc_pkg;

	localparam int DATA_DEPTH = 128;
	localparam int CODE_DEPTH = 128;
	localparam int DA_W = $clog2(DATA_DEPTH);

	localparam int FIFO_DEPTH = 3;
	localparam int FP_W = $clog2(FIFO_DEPTH);
	localparam int FC_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] RAM_BASE = 8'h80;

	localparam logic [3:0] OP_LOAD  = 4'h0;
	localparam logic [3:0] OP_STORE = 4'h2;
	localparam logic [3:0] OP_MOVE  = 4'h4;
	localparam logic [3:0] OP_LDI   = 4'h5;
	localparam logic [3:0] OP_ADD   = 4'h6;
	localparam logic [3:0] OP_SUB   = 4'h7;
	localparam logic [3:0] OP_SHL   = 4'h8;
	localparam logic [3:0] OP_SHR   = 4'h9;
	localparam logic [3:0] OP_TEST  = 4'hA;
	localparam logic [3:0] OP_OUT   = 4'hC;
	localparam logic [3:0] OP_IN    = 4'hD;
	localparam logic [3:0] OP_BRZ   = 4'hE;
	localparam logic [3:0] OP_BR    = 4'hF;

	typedef struct packed {
		logic            rd_en;
		logic            wr_en;
		logic [DA_W-1:0] idx;
		logic [7:0]      wdata;
	} mem_req_t;

	typedef struct packed {
		logic [7:0] next_pc;
		logic       out_valid;
		logic [7:0] out_value;
		logic       input_taken;
		logic       zero_flag;
		logic       overflow_flag;
		logic       halted;
	} res_t;

endpackage

@@ rtl/tfrc_dmem.sv @@
// data ram with per-entry valid bits and a registered read port
module tfrc_dmem (
	input  logic                clk,
	input  logic                arst_n,
	input  tfrc_pkg::mem_req_t  req,
	output logic [7:0]          rd_data
);

	logic [7:0]                      mem_q [tfrc_pkg::DATA_DEPTH];
	logic [tfrc_pkg::DATA_DEPTH-1:0] vld_q;
	logic [7:0]                      rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.idx] <= req.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.wr_en) begin
			vld_q[req.idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_q <= vld_q[req.idx] ? mem_q[req.idx] : 8'd0;
		end
	end

	assign rd_data = rd_q;

endmodule

@@ rtl/tfrc_exec.sv @@
// architectural state, decode and execute, with load forwarding from the ram read port
module tfrc_exec (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [7:0]          instruction_byte,
	input  logic [7:0]          input_value,
	input  logic [7:0]          mem_rd,
	output tfrc_pkg::mem_req_t  mem_req,
	output logic                res_vld,
	output tfrc_pkg::res_t      res
);

	logic [7:0]     regs_q [4];
	logic [7:0]     pc_q;
	logic           z_q;
	logic           o_q;
	logic           halt_q;
	logic           ld_pend_q;

	logic           s1_vld_s1;
	tfrc_pkg::res_t res_s1;
	logic           zsel_s1;

	logic [7:0]     er [4];
	logic           ez;
	logic [7:0]     nr [4];
	logic           nz;
	logic           no;
	logic [7:0]     npc;
	logic           nh;
	logic           outen;
	logic [7:0]     outv;
	logic           took;
	logic           ld;
	logic           st;

	logic [3:0]     op;
	logic [3:0]     nib;
	logic [1:0]     rx;
	logic [1:0]     ry;
	logic [7:0]     pc_inc;
	logic [7:0]     addr;
	logic           hit;
	logic [7:0]     tgt;
	logic [8:0]     sum;
	logic [7:0]     diff;

	always_comb begin
		er = regs_q;
		if (ld_pend_q) begin
			er[0] = mem_rd;
		end
		ez = ld_pend_q ? (mem_rd == 8'd0) : z_q;
	end

	assign op     = instruction_byte[7:4];
	assign nib    = instruction_byte[3:0];
	assign rx     = nib[3:2];
	assign ry     = nib[1:0];
	assign pc_inc = pc_q + 8'd1;
	assign addr   = er[ry];
	assign hit    = (addr >= tfrc_pkg::RAM_BASE)
		&& ({1'b0, addr[6:0]} < 8'(tfrc_pkg::DATA_DEPTH));
	assign tgt    = er[ry];
	assign sum    = {1'b0, er[rx]} + {1'b0, er[ry]};
	assign diff   = er[rx] - er[ry];

	always_comb begin
		nr    = er;
		nz    = ez;
		no    = o_q;
		npc   = pc_q;
		nh    = halt_q;
		outen = 1'b0;
		outv  = 8'd0;
		took  = 1'b0;
		ld    = 1'b0;
		st    = 1'b0;
		if (!halt_q) begin
			if (pc_q >= 8'(tfrc_pkg::CODE_DEPTH)) begin
				nh = 1'b1;
			end else begin
				npc = pc_inc;
				case (op)
					tfrc_pkg::OP_LOAD: begin
						ld = hit;
					end
					tfrc_pkg::OP_STORE: begin
						st = hit;
						if (hit) begin
							nz = (er[0] == 8'd0);
						end
					end
					tfrc_pkg::OP_MOVE: begin
						nr[ry] = er[rx];
						nz     = (er[rx] == 8'd0);
					end
					tfrc_pkg::OP_LDI: begin
						nr[0] = {4'd0, nib};
						nz    = (nib == 4'd0);
					end
					tfrc_pkg::OP_ADD: begin
						nr[rx] = sum[7:0];
						nz     = (sum[7:0] == 8'd0);
						no     = sum[8];
					end
					tfrc_pkg::OP_SUB: begin
						nr[rx] = diff;
						nz     = (diff == 8'd0);
						no     = (er[rx] < er[ry]);
					end
					tfrc_pkg::OP_SHL: begin
						nr[ry] = {er[ry][3:0], 4'd0};
					end
					tfrc_pkg::OP_SHR: begin
						nr[ry] = {4'd0, er[ry][7:4]};
					end
					tfrc_pkg::OP_TEST: begin
						nz = (er[ry] == 8'd0);
					end
					tfrc_pkg::OP_OUT: begin
						outen = 1'b1;
						outv  = er[ry];
					end
					tfrc_pkg::OP_IN: begin
						nr[ry] = input_value;
						nz     = (input_value == 8'd0);
						took   = 1'b1;
					end
					tfrc_pkg::OP_BRZ: begin
						if (ez) begin
							if (tgt < 8'(tfrc_pkg::CODE_DEPTH)) begin
								npc = tgt;
							end else begin
								npc = pc_q;
								nh  = 1'b1;
							end
						end
					end
					tfrc_pkg::OP_BR: begin
						if (tgt < 8'(tfrc_pkg::CODE_DEPTH)) begin
							npc = tgt;
						end else begin
							npc = pc_q;
							nh  = 1'b1;
						end
					end
					default: begin
						npc = pc_q;
						nh  = 1'b1;
					end
				endcase
			end
		end
	end

	always_comb begin
		mem_req.rd_en = accept && ld;
		mem_req.wr_en = accept && st;
		mem_req.idx   = addr[tfrc_pkg::DA_W-1:0];
		mem_req.wdata = er[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				regs_q[i] <= 8'd0;
			end
			pc_q      <= 8'd0;
			z_q       <= 1'b0;
			o_q       <= 1'b0;
			halt_q    <= 1'b0;
			ld_pend_q <= 1'b0;
			s1_vld_s1 <= 1'b0;
		end else begin
			s1_vld_s1 <= accept;
			if (accept) begin
				regs_q    <= nr;
				pc_q      <= npc;
				z_q       <= nz;
				o_q       <= no;
				halt_q    <= nh;
				ld_pend_q <= ld;
			end else if (ld_pend_q) begin
				regs_q[0] <= mem_rd;
				z_q       <= (mem_rd == 8'd0);
				ld_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1.next_pc       <= npc;
			res_s1.out_valid     <= outen;
			res_s1.out_value     <= outv;
			res_s1.input_taken   <= took;
			res_s1.zero_flag     <= nz;
			res_s1.overflow_flag <= no;
			res_s1.halted        <= nh;
			zsel_s1              <= ld;
		end
	end

	always_comb begin
		res = res_s1;
		if (zsel_s1) begin
			res.zero_flag = (mem_rd == 8'd0);
		end
	end

	assign res_vld = s1_vld_s1;

endmodule

@@ rtl/tfrc_ofifo.sv @@
// three-entry result queue in front of the output channel
module tfrc_ofifo (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  tfrc_pkg::res_t               din,
	input  logic                         pop,
	output logic                         not_empty,
	output tfrc_pkg::res_t               dout,
	output logic [tfrc_pkg::FC_W-1:0]    count
);

	tfrc_pkg::res_t                  ent_q [tfrc_pkg::FIFO_DEPTH];
	logic [tfrc_pkg::FP_W-1:0]       wp_q;
	logic [tfrc_pkg::FP_W-1:0]       rp_q;
	logic [tfrc_pkg::FC_W-1:0]       cnt_q;

	function automatic logic [tfrc_pkg::FP_W-1:0] ptr_inc(input logic [tfrc_pkg::FP_W-1:0] p);
		ptr_inc = (p == tfrc_pkg::FP_W'(tfrc_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= ptr_inc(wp_q);
			end
			if (pop) begin
				rp_q <= ptr_inc(rp_q);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign not_empty = (cnt_q != '0);
	assign dout      = ent_q[rp_q];
	assign count     = cnt_q;

endmodule

@@ rtl/tiny_four_register_cpu_execute.sv @@
// top level of the four-register cpu execute block
// Input channel inst_valid/inst_ready carries one instruction per transaction:
// instruction_byte, the byte fetched at the current pc, and input_value, the
// value an input instruction loads. Output channel res_valid/res_ready carries
// one result per instruction: next_pc, out_valid, out_value, input_taken,
// zero_flag, overflow_flag and halted.
// A result is offered once it has passed the execute stage register and
// then the result queue register.
// Throughput: one instruction per cycle while the queue has room, set by
// the single execute stage; a load's ram read lands in the next cycle and
// is forwarded into r0 and the zero flag for the next instruction, so loads
// do not stall. Reset clears pc, registers, flags and the halt bit, and the
// per-entry valid bits of the data ram, so unwritten ram reads as zero and
// no clearing pass is needed; inst_ready is high right after reset.
// When the receiver stalls, a three-entry result queue absorbs the results
// still in flight and inst_ready drops once it can take no more.
module tiny_four_register_cpu_execute (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       inst_valid,
	output logic       inst_ready,
	input  logic [7:0] instruction_byte,
	input  logic [7:0] input_value,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [7:0] next_pc,
	output logic       out_valid,
	output logic [7:0] out_value,
	output logic       input_taken,
	output logic       zero_flag,
	output logic       overflow_flag,
	output logic       halted
);

	tfrc_pkg::mem_req_t           mem_req;
	logic [7:0]                   mem_rd;
	logic                         accept;
	logic                         s1_vld;
	tfrc_pkg::res_t               s1_res;
	tfrc_pkg::res_t               q_res;
	logic                         q_ne;
	logic [tfrc_pkg::FC_W-1:0]    q_cnt;
	logic [tfrc_pkg::FC_W:0]      occ;
	logic                         pop;

	assign occ        = {1'b0, q_cnt} + {{tfrc_pkg::FC_W{1'b0}}, s1_vld};
	assign inst_ready = (occ < (tfrc_pkg::FC_W + 1)'(tfrc_pkg::FIFO_DEPTH));
	assign accept     = inst_valid && inst_ready;
	assign pop        = res_valid && res_ready;

	tfrc_exec u_exec (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (accept),
		.instruction_byte (instruction_byte),
		.input_value      (input_value),
		.mem_rd           (mem_rd),
		.mem_req          (mem_req),
		.res_vld          (s1_vld),
		.res              (s1_res)
	);

	tfrc_dmem u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (mem_rd)
	);

	tfrc_ofifo u_ofifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_vld),
		.din       (s1_res),
		.pop       (pop),
		.not_empty (q_ne),
		.dout      (q_res),
		.count     (q_cnt)
	);

	assign res_valid     = q_ne;
	assign next_pc       = q_res.next_pc;
	assign out_valid     = q_res.out_valid;
	assign out_value     = q_res.out_value;
	assign input_taken   = q_res.input_taken;
	assign zero_flag     = q_res.zero_flag;
	assign overflow_flag = q_res.overflow_flag;
	assign halted        = q_res.halted;

	// queue must have room for every result still in the execute stage
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld && !pop |-> q_cnt != tfrc_pkg::FC_W'(tfrc_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	// a halted result never emits output or consumes input
	a_halt_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && halted |-> !out_valid && !input_taken)
		else $error("halted result with output or input activity");

	// a result without output carries a zero value
	a_out_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> out_value == 8'd0)
		else $error("out_value nonzero without output");

endmodule

@@ dv/tb_tiny_four_register_cpu_execute.sv @@
// testbench for the four-register cpu execute block: random programs, predicted results
module tb_tiny_four_register_cpu_execute;

	localparam logic [3:0] OP_RSV1 = 4'h1;
	localparam logic [3:0] OP_RSV3 = 4'h3;
	localparam logic [3:0] OP_RSVB = 4'hB;

	localparam int LIVE = 0;
	localparam int PLAN = 1;

	localparam int N_RANDOM = 1650;
	localparam int N_AFTER_HALT = 16;

	typedef enum int {RX_OPEN, RX_CHOPPY, RX_TIGHT} rx_mode_t;

	typedef struct packed {
		logic [7:0] ins;
		logic [7:0] val;
	} instr_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       inst_valid = 1'b0;
	logic       inst_ready;
	logic [7:0] instruction_byte = 8'h00;
	logic [7:0] input_value = 8'h00;
	logic       res_valid;
	logic       res_ready = 1'b0;
	logic [7:0] next_pc;
	logic       out_valid;
	logic [7:0] out_value;
	logic       input_taken;
	logic       zero_flag;
	logic       overflow_flag;
	logic       halted;

	// cpu state, one copy for the predictor and one for program planning
	bit [7:0] cpu_pc [2];
	bit [7:0] cpu_reg [2][4];
	bit       cpu_z [2];
	bit       cpu_o [2];
	bit       cpu_stop [2];
	bit [7:0] cpu_ram [2][tfrc_pkg::DATA_DEPTH];

	instr_t          program_q [$];
	tfrc_pkg::res_t  result_q [$];

	int       errors = 0;
	int       n_checked = 0;
	int       n_sent = 0;
	int       n_out = 0;
	int       n_in = 0;
	string    halt_how = "none";

	int             gap_left;
	int             burst_left;
	rx_mode_t       rx_mode;
	int             mode_left;
	instr_t         drive_item;
	tfrc_pkg::res_t want;

	tiny_four_register_cpu_execute u_top (.*);

	always #4 clk = ~clk;

	function automatic tfrc_pkg::res_t execute(input int c, input logic [7:0] ins,
			input logic [7:0] inval);
		tfrc_pkg::res_t res;
		logic [3:0] op;
		logic [3:0] nib;
		logic [1:0] rx;
		logic [1:0] ry;
		logic [7:0] a;
		logic [7:0] b;
		logic [8:0] sum;
		logic [7:0] addr;
		bit         ram_hit;
		int         slot;
		bit         advance;
		bit         jump;
		res = '0;
		op = ins[7:4];
		nib = ins[3:0];
		rx = nib[3:2];
		ry = nib[1:0];
		advance = 1'b1;
		jump = 1'b0;
		if (!cpu_stop[c] && cpu_pc[c] >= tfrc_pkg::CODE_DEPTH)
			cpu_stop[c] = 1'b1;
		if (!cpu_stop[c]) begin
			a = cpu_reg[c][rx];
			b = cpu_reg[c][ry];
			addr = b;
			ram_hit = addr >= tfrc_pkg::RAM_BASE
				&& (addr - tfrc_pkg::RAM_BASE) < tfrc_pkg::DATA_DEPTH;
			slot = int'(addr - tfrc_pkg::RAM_BASE);
			case (op)
				tfrc_pkg::OP_LOAD: begin
					if (ram_hit) begin
						cpu_reg[c][0] = cpu_ram[c][slot];
						cpu_z[c] = cpu_reg[c][0] == 8'h00;
					end
				end
				tfrc_pkg::OP_STORE: begin
					if (ram_hit) begin
						cpu_ram[c][slot] = cpu_reg[c][0];
						cpu_z[c] = cpu_reg[c][0] == 8'h00;
					end
				end
				tfrc_pkg::OP_MOVE: begin
					cpu_reg[c][ry] = a;
					cpu_z[c] = a == 8'h00;
				end
				tfrc_pkg::OP_LDI: begin
					cpu_reg[c][0] = {4'h0, nib};
					cpu_z[c] = nib == 4'h0;
				end
				tfrc_pkg::OP_ADD: begin
					sum = {1'b0, a} + {1'b0, b};
					cpu_reg[c][rx] = sum[7:0];
					cpu_z[c] = sum[7:0] == 8'h00;
					cpu_o[c] = sum[8];
				end
				tfrc_pkg::OP_SUB: begin
					cpu_o[c] = a < b;
					cpu_reg[c][rx] = a - b;
					cpu_z[c] = (a - b) == 8'h00;
				end
				tfrc_pkg::OP_SHL: cpu_reg[c][ry] = b << 4;
				tfrc_pkg::OP_SHR: cpu_reg[c][ry] = b >> 4;
				tfrc_pkg::OP_TEST: cpu_z[c] = b == 8'h00;
				tfrc_pkg::OP_OUT: begin
					res.out_valid = 1'b1;
					res.out_value = b;
				end
				tfrc_pkg::OP_IN: begin
					cpu_reg[c][ry] = inval;
					cpu_z[c] = inval == 8'h00;
					res.input_taken = 1'b1;
				end
				tfrc_pkg::OP_BRZ: jump = cpu_z[c];
				tfrc_pkg::OP_BR: jump = 1'b1;
				default: begin
					cpu_stop[c] = 1'b1;
					advance = 1'b0;
				end
			endcase
			if (jump) begin
				advance = 1'b0;
				if (b < tfrc_pkg::CODE_DEPTH)
					cpu_pc[c] = b;
				else
					cpu_stop[c] = 1'b1;
			end
			if (advance)
				cpu_pc[c] = cpu_pc[c] + 8'd1;
		end
		res.next_pc = cpu_pc[c];
		res.zero_flag = cpu_z[c];
		res.overflow_flag = cpu_o[c];
		res.halted = cpu_stop[c];
		return res;
	endfunction

	function automatic logic [3:0] random_opcode(input bit with_branch);
		int pick;
		pick = $urandom_range(0, with_branch ? 99 : 85);
		if (pick < 10) return tfrc_pkg::OP_LOAD;
		if (pick < 20) return tfrc_pkg::OP_STORE;
		if (pick < 27) return tfrc_pkg::OP_MOVE;
		if (pick < 33) return tfrc_pkg::OP_LDI;
		if (pick < 40) return tfrc_pkg::OP_ADD;
		if (pick < 47) return tfrc_pkg::OP_SUB;
		if (pick < 52) return tfrc_pkg::OP_SHL;
		if (pick < 57) return tfrc_pkg::OP_SHR;
		if (pick < 62) return tfrc_pkg::OP_TEST;
		if (pick < 72) return tfrc_pkg::OP_OUT;
		if (pick < 86) return tfrc_pkg::OP_IN;
		if (pick < 93) return tfrc_pkg::OP_BRZ;
		return tfrc_pkg::OP_BR;
	endfunction

	// queue one instruction and run it on the planning copy
	task automatic plan(input logic [3:0] op, input logic [3:0] nib, input logic [7:0] val);
		instr_t it;
		it.ins = {op, nib};
		it.val = val;
		program_q.push_back(it);
		void'(execute(PLAN, it.ins, it.val));
	endtask

	task automatic compare_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inst_valid <= 1'b0;
			instruction_byte <= 8'h00;
			input_value <= 8'h00;
			gap_left = 0;
			burst_left = 1;
		end else begin
			if (inst_valid && inst_ready) begin
				want = execute(LIVE, instruction_byte, input_value);
				result_q.push_back(want);
				n_sent++;
				if (want.out_valid) n_out++;
				if (want.input_taken) n_in++;
			end
			if (!inst_valid || inst_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					inst_valid <= 1'b0;
				end else if (program_q.size() > 0) begin
					drive_item = program_q.pop_front();
					instruction_byte <= drive_item.ins;
					input_value <= drive_item.val;
					inst_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
						burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
							: $urandom_range(1, 12);
					end
				end else begin
					inst_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
			rx_mode = RX_OPEN;
			mode_left = 0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(8, 60);
			end
			mode_left--;
			case (rx_mode)
				RX_OPEN: res_ready <= 1'b1;
				RX_CHOPPY: res_ready <= 1'($urandom_range(0, 1));
				default: res_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (result_q.size() == 0) begin
				$display("%0t: result with no transaction outstanding, expected none, actual pc %0h",
					$time, next_pc);
				errors++;
			end else begin
				tfrc_pkg::res_t exp_r;
				exp_r = result_q.pop_front();
				compare_field("next_pc", exp_r.next_pc, next_pc);
				compare_field("out_valid", 8'(exp_r.out_valid), 8'(out_valid));
				compare_field("out_value", exp_r.out_value, out_value);
				compare_field("input_taken", 8'(exp_r.input_taken), 8'(input_taken));
				compare_field("zero_flag", 8'(exp_r.zero_flag), 8'(zero_flag));
				compare_field("overflow_flag", 8'(exp_r.overflow_flag), 8'(overflow_flag));
				compare_field("halted", 8'(exp_r.halted), 8'(halted));
				n_checked++;
			end
		end
	end

	initial begin
		#3000000;
		$display("timeout with %0d results outstanding", result_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int         i;
		logic [3:0] op;
		logic [3:0] nib;
		logic [7:0] val;
		logic [7:0] tgt;

		// directed: ram bounds, every operation, carry and borrow, branches
		plan(tfrc_pkg::OP_LDI, 4'hF, 8'h00);
		plan(tfrc_pkg::OP_IN, 4'h1, 8'h80);
		plan(tfrc_pkg::OP_STORE, 4'h1, 8'hFF);
		plan(tfrc_pkg::OP_IN, 4'h2, 8'hFF);
		plan(tfrc_pkg::OP_STORE, 4'h2, 8'h00);
		plan(tfrc_pkg::OP_IN, 4'h3, 8'h00);
		plan(tfrc_pkg::OP_STORE, 4'h3, 8'h55);
		plan(tfrc_pkg::OP_LDI, 4'h0, 8'hAA);
		plan(tfrc_pkg::OP_LOAD, 4'h1, 8'h00);
		plan(tfrc_pkg::OP_LOAD, 4'h2, 8'hFF);
		plan(tfrc_pkg::OP_LOAD, 4'h3, 8'h00);
		plan(tfrc_pkg::OP_LOAD, 4'h0, 8'h00);
		plan(tfrc_pkg::OP_MOVE, 4'h9, 8'h00);
		plan(tfrc_pkg::OP_ADD, 4'h6, 8'h00);
		plan(tfrc_pkg::OP_SUB, 4'hE, 8'h00);
		plan(tfrc_pkg::OP_SHL, 4'h1, 8'h00);
		plan(tfrc_pkg::OP_SHR, 4'hD, 8'h00);
		plan(tfrc_pkg::OP_TEST, 4'h3, 8'h00);
		plan(tfrc_pkg::OP_OUT, 4'h2, 8'h00);
		plan(tfrc_pkg::OP_OUT, 4'hD, 8'h00);
		plan(tfrc_pkg::OP_SUB, 4'h5, 8'h00);
		plan(tfrc_pkg::OP_BRZ, 4'h3, 8'h00);
		plan(tfrc_pkg::OP_TEST, 4'h2, 8'h00);
		plan(tfrc_pkg::OP_BRZ, 4'h2, 8'h00);
		plan(tfrc_pkg::OP_LDI, 4'hC, 8'h00);
		plan(tfrc_pkg::OP_BR, 4'h0, 8'h00);

		// random programs kept running: no halts, pc pulled back before the code end
		for (i = 0; i < N_RANDOM; i++) begin
			if (cpu_pc[PLAN] >= 8'd112) begin
				plan(tfrc_pkg::OP_LDI, 4'($urandom), 8'($urandom));
				plan(tfrc_pkg::OP_BR, {2'($urandom), 2'd0}, 8'($urandom));
				continue;
			end
			op = random_opcode(1'b1);
			nib = 4'($urandom);
			val = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 127)) : 8'($urandom);
			tgt = cpu_reg[PLAN][nib[1:0]];
			if ((op == tfrc_pkg::OP_BR || (op == tfrc_pkg::OP_BRZ && cpu_z[PLAN]))
					&& tgt >= 8'(tfrc_pkg::CODE_DEPTH - 1))
				op = tfrc_pkg::OP_TEST;
			plan(op, nib, val);
		end
		if (cpu_pc[PLAN] >= 8'd112) begin
			plan(tfrc_pkg::OP_LDI, 4'($urandom), 8'($urandom));
			plan(tfrc_pkg::OP_BR, {2'($urandom), 2'd0}, 8'($urandom));
		end

		// end the program with one way of halting
		case ($urandom_range(0, 2))
			0: begin
				halt_how = "undefined opcode";
				case ($urandom_range(0, 2))
					0: op = OP_RSV1;
					1: op = OP_RSV3;
					default: op = OP_RSVB;
				endcase
				plan(op, 4'($urandom), 8'($urandom));
			end
			1: begin
				halt_how = "bad branch target";
				plan(tfrc_pkg::OP_IN, {2'($urandom), 2'd1}, 8'h80 | 8'($urandom));
				if ($urandom_range(0, 1)) begin
					plan(tfrc_pkg::OP_BR, {2'($urandom), 2'd1}, 8'($urandom));
				end else begin
					plan(tfrc_pkg::OP_LDI, 4'h0, 8'($urandom));
					plan(tfrc_pkg::OP_BRZ, {2'($urandom), 2'd1}, 8'($urandom));
				end
			end
			default: begin
				halt_how = "pc past the code";
				while (!cpu_stop[PLAN])
					plan(random_opcode(1'b0), 4'($urandom), 8'($urandom));
			end
		endcase
		for (i = 0; i < N_AFTER_HALT; i++)
			plan(4'($urandom), 4'($urandom), 8'($urandom));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (program_q.size() != 0 || inst_valid || result_q.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
		if (result_q.size() != 0) begin
			$display("%0t: %0d results never arrived, expected pc %0h, actual none",
				$time, result_q.size(), result_q[0].next_pc);
			errors++;
		end

		$display("checked %0d results for %0d instructions: %0d outputs, %0d inputs taken",
			n_checked, n_sent, n_out, n_in);
		$display("program stopped by %s, then %0d instructions sent while halted",
			halt_how, N_AFTER_HALT);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
